// ===== hdl/lkt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkt_pkg: shared types and constants of the LRU key tracker
// Field widths, register map and the control word that rides the cell chain.
// ----------------------------------------------------------------------------
package lkt_pkg;

    // Fixed field widths of the channels
    localparam int KEY_W        = 16;
    localparam int OPEN_LIMIT_W = 9;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0]    REG_OPEN_LIMIT   = 1'b0;
    localparam logic [OPEN_LIMIT_W-1:0] OPEN_LIMIT_RESET = 9'd256;

    // Control word of one item travelling down the chain
    typedef struct packed {
        logic valid;   // an item occupies this slot
        logic active;  // still searching for its key
        logic hit;     // key found in a held entry
        logic evict;   // least recent key dropped, carried in the data word
    } tok_ctrl_t;

endpackage

// ===== hdl/lkt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkt_cell: one entry of the recency chain
// Holds one key and its live flag. An active item swaps its carried key in,
// finishes on a match or at the end of the live region, and moves on.
// ----------------------------------------------------------------------------
module lkt_cell #(
    parameter int INDEX    = 0,
    parameter int KEY_BITS = 16,
    parameter int LIM_W    = 9
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic [LIM_W-1:0]     lim,
    input  lkt_pkg::tok_ctrl_t   ctl_in,
    input  logic [KEY_BITS-1:0]  key_in,
    input  logic [KEY_BITS-1:0]  carry_in,
    output lkt_pkg::tok_ctrl_t   ctl_out,
    output logic [KEY_BITS-1:0]  key_out,
    output logic [KEY_BITS-1:0]  carry_out,
    output logic                 live
);
    import lkt_pkg::*;

    logic                live_reg;
    logic                live_next;
    logic [KEY_BITS-1:0] value_reg;
    logic [KEY_BITS-1:0] value_next;
    tok_ctrl_t           ctl_reg;
    tok_ctrl_t           ctl_next;
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] carry_reg;
    logic [KEY_BITS-1:0] carry_next;
    logic                at_limit;

    // A miss reaching this position with the set full drops the tail key
    assign at_limit = (LIM_W'(INDEX) >= lim);

    always_comb
    begin
        live_next  = live_reg;
        value_next = value_reg;
        ctl_next   = ctl_in;
        carry_next = carry_in;
        if (ctl_in.valid && ctl_in.active)
        begin
            if (live_reg)
            begin
                value_next = carry_in;
                if (value_reg == key_in)
                begin
                    ctl_next.active = 1'b0;
                    ctl_next.hit    = 1'b1;
                    carry_next      = '0;
                end
                else
                begin
                    carry_next = value_reg;
                end
            end
            else if (at_limit)
            begin
                // carry holds the least recent key: report it, keep the cell empty
                ctl_next.active = 1'b0;
                ctl_next.evict  = 1'b1;
            end
            else
            begin
                live_next       = 1'b1;
                value_next      = carry_in;
                ctl_next.active = 1'b0;
                carry_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
            ctl_reg  <= '0;
        end
        else if (adv)
        begin
            live_reg <= live_next;
            ctl_reg  <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            value_reg <= value_next;
            key_reg   <= key_in;
            carry_reg <= carry_next;
        end
    end

    assign ctl_out   = ctl_reg;
    assign key_out   = key_reg;
    assign carry_out = carry_reg;
    assign live      = live_reg;

`ifndef ASSERT_OFF
    a_outcome_excl: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.valid |-> !(ctl_reg.hit && ctl_reg.evict))
        else $error("lkt_cell: item both hit and evicted");
    a_done_not_active: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg.valid && (ctl_reg.hit || ctl_reg.evict)) |-> !ctl_reg.active)
        else $error("lkt_cell: finished item still searching");
    a_live_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg |=> live_reg)
        else $error("lkt_cell: live entry lost");
`endif

endmodule

// ===== hdl/lru_key_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_tracker: fully associative least-recently-used key tracker
// Move-to-front chain of CAPACITY cells with an APB register for the limit.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: key with in_valid / in_stall. Output channel: hit,
//   evicted_valid, evicted_key with out_valid / out_stall. One result item
//   for every input item, in order.
//   Each item walks the cell chain one cell per cycle while the chain is not
//   frozen, swapping keys as it goes, so items follow each other back to back:
//   one item per cycle. An accepted item passes the CAPACITY cell registers and
//   then the output register; the chain length sets the latency.
//   The open-key limit (APB address 0) caps the number of held keys; 0 acts
//   as 1 and values above CAPACITY act as CAPACITY. Write it only while no
//   item is in flight.
//   Reset empties the chain and sets the limit to 256. No clearing pass.
//   While a result is held by out_stall, the whole chain freezes and
//   in_stall is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module lru_key_tracker #(
    parameter int CAPACITY = 256,
    parameter int KEY_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lkt_pkg::KEY_W-1:0]         key,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic                              evicted_valid,
    output logic [lkt_pkg::KEY_W-1:0]         evicted_key,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lkt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lkt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lkt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import lkt_pkg::*;

    localparam int LIM_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (LIM_W > OPEN_LIMIT_W) ? LIM_W : OPEN_LIMIT_W;

    logic [OPEN_LIMIT_W-1:0] open_limit_reg;
    logic [CMP_W-1:0]        open_limit_ext;
    logic [LIM_W-1:0]        lim;
    logic [REG_IDX_W-1:0]    reg_idx;
    logic                    adv;

    tok_ctrl_t             ctl_w   [CAPACITY+1];
    logic [KEY_BITS-1:0]   key_w   [CAPACITY+1];
    logic [KEY_BITS-1:0]   carry_w [CAPACITY+1];
    logic [CAPACITY-1:0]   live_w;

    logic                  out_valid_reg;
    logic                  hit_reg;
    logic                  evicted_valid_reg;
    logic [KEY_W-1:0]      evicted_key_reg;

    // ---------------- configuration ----------------
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_limit_reg <= OPEN_LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready && (reg_idx == REG_OPEN_LIMIT))
        begin
            open_limit_reg <= pwdata[OPEN_LIMIT_W-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_OPEN_LIMIT: prdata = APB_DATA_W'(open_limit_reg);
            default:        prdata = '0;
        endcase
    end

    // clamp the limit to 1 .. CAPACITY
    assign open_limit_ext = CMP_W'(open_limit_reg);

    always_comb
    begin
        priority if (open_limit_reg == '0)
            lim = LIM_W'(1);
        else if (open_limit_ext > CMP_W'(CAPACITY))
            lim = LIM_W'(CAPACITY);
        else
            lim = LIM_W'(open_limit_ext);
    end

    // ---------------- cell chain ----------------
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    assign ctl_w[0]   = '{valid: in_valid, active: 1'b1, hit: 1'b0, evict: 1'b0};
    assign key_w[0]   = KEY_BITS'(key);
    assign carry_w[0] = KEY_BITS'(key);

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        lkt_cell #(
            .INDEX    (i),
            .KEY_BITS (KEY_BITS),
            .LIM_W    (LIM_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .lim       (lim),
            .ctl_in    (ctl_w[i]),
            .key_in    (key_w[i]),
            .carry_in  (carry_w[i]),
            .ctl_out   (ctl_w[i+1]),
            .key_out   (key_w[i+1]),
            .carry_out (carry_w[i+1]),
            .live      (live_w[i])
        );
    end

    // ---------------- result register ----------------
    // An item still searching past the last cell drops the tail key it carries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= ctl_w[CAPACITY].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg           <= ctl_w[CAPACITY].hit;
            evicted_valid_reg <= ctl_w[CAPACITY].evict || ctl_w[CAPACITY].active;
            evicted_key_reg   <= KEY_W'(carry_w[CAPACITY]);
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_key   = evicted_key_reg;

`ifndef ASSERT_OFF
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && hit_reg) |-> !evicted_valid_reg)
        else $error("lru_key_tracker: hit reported with an eviction");
    a_clean_key: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !evicted_valid_reg) |-> (evicted_key_reg == '0))
        else $error("lru_key_tracker: evicted key not zero without eviction");
    a_front_live: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> live_w[0])
        else $error("lru_key_tracker: front entry empty after an item");
    for (genvar j = 0; j + 1 < CAPACITY; j++)
    begin : g_chk
        a_thermo: assert property (@(posedge clk) disable iff (!rst_n)
            live_w[j+1] |-> live_w[j])
            else $error("lru_key_tracker: gap in the live entries");
    end
`endif

endmodule
